// ===== hdl/mscb_pkg.sv =====
// shared types, codes and widths for the countdown timer bank
// no dependencies; imported by every module of the bank
package mscb_pkg;

    // default sizing, handed to the top level parameters
    localparam int TIMER_SLOTS_DEF = 16;
    localparam int GEN_BITS_DEF    = 16;

    // field widths of the channels
    localparam int CMD_W      = 2;
    localparam int DELTA_W    = 16;
    localparam int RATE_W     = 24;
    localparam int DELAY_W    = 23;
    localparam int SLOT_OUT_W = 4;
    localparam int GEN_OUT_W  = 16;
    localparam int KIND_W     = 2;

    // stored timer fields
    localparam int REM_W = 26;
    localparam int PER_W = 23;

    // expiry beats per tick are capped
    localparam int MAX_EVENTS = 16;
    localparam int EVT_CNT_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SET       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;       // latch the input beat
        logic tick_start;   // reset expiry bookkeeping
        logic clr;          // free the addressed slot, build clear reply
        logic set_invalid;  // build invalid-handle reply
        logic set_take;     // claim the free slot at the find index
        logic set_full;     // build table-full reply
        logic proc_en;      // update the slot in the process stage
        logic flush;        // send the final beat of a tick
        logic reply_send;   // send the held reply
    } mscb_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // output register can take a beat
        logic rate_ok;      // rate on the input is positive
        logic slot_free;    // slot at the find index is not live
    } mscb_stat_t;

endpackage

// ===== hdl/mscb_ctrl.sv =====
// sequencer of the timer bank: accepts commands, walks the slots
// depends on mscb_pkg
module mscb_ctrl
    import mscb_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CMD_W-1:0]      cmd,
    input  mscb_stat_t            stat,
    output mscb_ctl_t             ctl,
    output logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] rd_addr,
    output logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] proc_idx,
    output logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] find_idx
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_FIND,
        S_REPLY
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                proc_valid_reg, proc_valid_next;
    logic [SLOT_W-1:0]   proc_idx_reg, proc_idx_next;
    logic                adv;

    // process stage moves on when empty or when the output can take a beat
    assign adv = !proc_valid_reg || stat.out_free;

    always_comb
    begin
        ctl             = '0;
        state_next      = state_reg;
        idx_next        = idx_reg;
        proc_valid_next = proc_valid_reg;
        proc_idx_next   = proc_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    unique case (cmd)
                        CMD_TICK:
                        begin
                            ctl.tick_start  = 1'b1;
                            idx_next        = '0;
                            proc_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        CMD_SET:
                        begin
                            if (stat.rate_ok)
                            begin
                                idx_next   = '0;
                                state_next = S_FIND;
                            end
                            else
                            begin
                                ctl.set_invalid = 1'b1;
                                state_next      = S_REPLY;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctl.clr    = 1'b1;
                            state_next = S_REPLY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (adv)
                begin
                    ctl.proc_en = proc_valid_reg;
                    if (idx_reg == CNT_W'(TIMER_SLOTS))
                    begin
                        proc_valid_next = 1'b0;
                        state_next      = S_FLUSH;
                    end
                    else
                    begin
                        proc_valid_next = 1'b1;
                        proc_idx_next   = idx_reg[SLOT_W-1:0];
                        idx_next        = idx_reg + 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    ctl.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIND:
            begin
                if (stat.slot_free)
                begin
                    ctl.set_take = 1'b1;
                    state_next   = S_REPLY;
                end
                else if (idx_reg == CNT_W'(TIMER_SLOTS - 1))
                begin
                    ctl.set_full = 1'b1;
                    state_next   = S_REPLY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    ctl.reply_send = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    // on a held process stage, re-read its slot so the read data stays put
    assign rd_addr  = (proc_valid_reg && !adv) ? proc_idx_reg : idx_reg[SLOT_W-1:0];
    assign proc_idx = proc_idx_reg;
    assign find_idx = idx_reg[SLOT_W-1:0];

endmodule

// ===== hdl/mscb_datapath.sv =====
// timer storage, live bits, generation counter and result registers
// depends on mscb_pkg; driven by mscb_ctrl
module mscb_datapath
    import mscb_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
    parameter int GEN_BITS    = GEN_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mscb_ctl_t               ctl,
    output mscb_stat_t              stat,
    input  logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] rd_addr,
    input  logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] proc_idx,
    input  logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] find_idx,
    input  logic [DELTA_W-1:0]      delta,
    input  logic signed [RATE_W-1:0] rate,
    input  logic [DELAY_W-1:0]      delay,
    input  logic                    is_loop,
    input  logic [SLOT_OUT_W-1:0]   slot,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [KIND_W-1:0]       kind,
    output logic [SLOT_OUT_W-1:0]   handle_slot,
    output logic [GEN_OUT_W-1:0]    handle_generation,
    output logic                    handle_valid,
    output logic                    table_full,
    output logic                    last
);

    localparam int SLOT_W   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int MEM_W    = REM_W + PER_W + 1 + GEN_BITS;
    localparam int PER_LSB  = REM_W;
    localparam int FLAG_BIT = REM_W + PER_W;
    localparam int GEN_LSB  = REM_W + PER_W + 1;

    // timer memory: remaining time, period, loop flag, generation
    logic [MEM_W-1:0]          tmr_mem_reg [TIMER_SLOTS];
    logic [MEM_W-1:0]          rd_data_reg;
    logic                      mem_we;
    logic [SLOT_W-1:0]         mem_waddr;
    logic [MEM_W-1:0]          mem_wdata;

    logic [TIMER_SLOTS-1:0]    live_reg;
    logic [GEN_BITS-1:0]       gen_reg;
    logic [GEN_BITS-1:0]       gen_inc;
    logic [GEN_BITS-1:0]       gen_new;

    // latched input beat
    logic [DELTA_W-1:0]        delta_reg;
    logic [PER_W-1:0]          rate_reg;
    logic [DELAY_W-1:0]        delay_reg;
    logic                      loop_reg;

    // held single reply
    logic [KIND_W-1:0]         rep_kind_reg;
    logic [SLOT_OUT_W-1:0]     rep_slot_reg;
    logic [GEN_OUT_W-1:0]      rep_gen_reg;
    logic                      rep_valid_reg;
    logic                      rep_full_reg;

    // expiry waiting for the next one, so the final one can carry last
    logic                      pend_valid_reg;
    logic [SLOT_OUT_W-1:0]     pend_slot_reg;
    logic [GEN_OUT_W-1:0]      pend_gen_reg;
    logic [EVT_CNT_W-1:0]      ev_cnt_reg;

    logic                      out_valid_reg;
    logic [KIND_W-1:0]         kind_reg;
    logic [SLOT_OUT_W-1:0]     slot_out_reg;
    logic [GEN_OUT_W-1:0]      gen_out_reg;
    logic                      valid_out_reg;
    logic                      full_out_reg;
    logic                      last_reg;

    logic                      live_p;
    logic [REM_W-1:0]          rem_sub;
    logic                      expire;
    logic                      hit;
    logic                      ev_room;
    logic                      push;
    logic                      out_load;
    logic                      slot_in_range;
    logic [SLOT_W-1:0]         clr_idx;
    logic                      out_free;

    // slot update in the process stage
    assign live_p  = live_reg[proc_idx];
    assign rem_sub = rd_data_reg[REM_W-1:0] - REM_W'(delta_reg);
    assign expire  = rem_sub[REM_W-1];
    assign hit     = ctl.proc_en && live_p && expire;
    assign ev_room = (ev_cnt_reg < EVT_CNT_W'(MAX_EVENTS));
    assign push    = hit && ev_room && pend_valid_reg;

    assign gen_inc = gen_reg + 1'b1;
    assign gen_new = ((gen_inc == '1) || (gen_inc == '0)) ? GEN_BITS'(1) : gen_inc;

    assign slot_in_range = (32'(slot) < 32'(TIMER_SLOTS));
    assign clr_idx       = SLOT_W'(slot);

    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = ctl.reply_send || ctl.flush || push;

    assign stat.out_free  = out_free;
    assign stat.rate_ok   = !rate[RATE_W-1] && (rate != '0);
    assign stat.slot_free = !live_reg[find_idx];

    // memory write port: set claims a slot, tick writes back a live slot
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = proc_idx;
        mem_wdata = rd_data_reg;
        if (ctl.set_take)
        begin
            mem_we    = 1'b1;
            mem_waddr = find_idx;
            mem_wdata = {gen_new, loop_reg, rate_reg,
                         REM_W'(rate_reg) + REM_W'(delay_reg)};
        end
        else if (ctl.proc_en && live_p)
        begin
            mem_we = 1'b1;
            if (expire && rd_data_reg[FLAG_BIT])
            begin
                mem_wdata[REM_W-1:0] = REM_W'(rd_data_reg[PER_LSB +: PER_W]);
            end
            else
            begin
                mem_wdata[REM_W-1:0] = rem_sub;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tmr_mem_reg[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tmr_mem_reg[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            gen_reg        <= '0;
            pend_valid_reg <= 1'b0;
            ev_cnt_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr && slot_in_range)
            begin
                live_reg[clr_idx] <= 1'b0;
            end
            else if (ctl.set_take)
            begin
                live_reg[find_idx] <= 1'b1;
            end
            else if (hit && !rd_data_reg[FLAG_BIT])
            begin
                live_reg[proc_idx] <= 1'b0;
            end

            if (ctl.set_take)
            begin
                gen_reg <= gen_new;
            end

            if (ctl.tick_start)
            begin
                pend_valid_reg <= 1'b0;
                ev_cnt_reg     <= '0;
            end
            else if (hit && ev_room)
            begin
                pend_valid_reg <= 1'b1;
                ev_cnt_reg     <= ev_cnt_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            delta_reg <= delta;
            rate_reg  <= rate[PER_W-1:0];
            delay_reg <= delay;
            loop_reg  <= is_loop;
        end

        if (hit && ev_room)
        begin
            pend_slot_reg <= SLOT_OUT_W'(proc_idx);
            pend_gen_reg  <= GEN_OUT_W'(rd_data_reg[GEN_LSB +: GEN_BITS]);
        end

        if (ctl.set_invalid || ctl.set_full)
        begin
            rep_kind_reg  <= KIND_SET;
            rep_slot_reg  <= '0;
            rep_gen_reg   <= '0;
            rep_valid_reg <= 1'b0;
            rep_full_reg  <= ctl.set_full;
        end
        else if (ctl.set_take)
        begin
            rep_kind_reg  <= KIND_SET;
            rep_slot_reg  <= SLOT_OUT_W'(find_idx);
            rep_gen_reg   <= GEN_OUT_W'(gen_new);
            rep_valid_reg <= 1'b1;
            rep_full_reg  <= 1'b0;
        end
        else if (ctl.clr)
        begin
            rep_kind_reg  <= KIND_CLEAR;
            rep_slot_reg  <= slot;
            rep_gen_reg   <= '0;
            rep_valid_reg <= 1'b0;
            rep_full_reg  <= 1'b0;
        end

        if (ctl.reply_send)
        begin
            kind_reg      <= rep_kind_reg;
            slot_out_reg  <= rep_slot_reg;
            gen_out_reg   <= rep_gen_reg;
            valid_out_reg <= rep_valid_reg;
            full_out_reg  <= rep_full_reg;
            last_reg      <= 1'b1;
        end
        else if (ctl.flush)
        begin
            kind_reg      <= pend_valid_reg ? KIND_EXPIRE : KIND_IDLE_TICK;
            slot_out_reg  <= pend_valid_reg ? pend_slot_reg : '0;
            gen_out_reg   <= pend_valid_reg ? pend_gen_reg : '0;
            valid_out_reg <= 1'b0;
            full_out_reg  <= 1'b0;
            last_reg      <= 1'b1;
        end
        else if (push)
        begin
            kind_reg      <= KIND_EXPIRE;
            slot_out_reg  <= pend_slot_reg;
            gen_out_reg   <= pend_gen_reg;
            valid_out_reg <= 1'b0;
            full_out_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign handle_slot       = slot_out_reg;
    assign handle_generation = gen_out_reg;
    assign handle_valid      = valid_out_reg;
    assign table_full        = full_out_reg;
    assign last              = last_reg;

endmodule

// ===== hdl/multi_slot_countdown_timer_bank_core.sv =====
// top level of the multi-slot countdown timer bank
// depends on mscb_pkg, mscb_ctrl and mscb_datapath
//
// A bank of TIMER_SLOTS countdown timers in fixed slots. A set beat (cmd 1) with a positive
// rate claims the lowest free slot, loads rate + delay as remaining time and returns one beat
// with the slot and a fresh generation number (wrapping back to 1); a non-positive rate or a
// full bank returns an invalid handle, the latter with table_full. A clear beat (cmd 2) frees
// a slot and returns one beat. A tick beat (cmd 0) subtracts delta from every live timer in slot
// order and returns one expiry beat per timer that drops below zero (at most 16 per tick; a
// periodic timer reloads its period, a one-shot timer frees its slot), or a single
// "no expiry" beat; the final beat of every command has last set. cmd 3 is taken and ignored.
// One command is worked on at a time. A tick walks the slots through the timer memory, one
// slot per cycle while the output can take a beat, before its final beat; a set tests the
// slots from the lowest upward until it finds a free one or reaches the last slot. Stall on
// the output holds the walk in place. No clearing pass is needed after reset: slots that were
// never claimed are not live.
module multi_slot_countdown_timer_bank_core
    import mscb_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
    parameter int GEN_BITS    = GEN_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // command channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         cmd,
    input  logic [DELTA_W-1:0]       delta,
    input  logic signed [RATE_W-1:0] rate,
    input  logic [DELAY_W-1:0]       delay,
    input  logic                     is_loop,
    input  logic [SLOT_OUT_W-1:0]    slot,

    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [KIND_W-1:0]        kind,
    output logic [SLOT_OUT_W-1:0]    handle_slot,
    output logic [GEN_OUT_W-1:0]     handle_generation,
    output logic                     handle_valid,
    output logic                     table_full,
    output logic                     last
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    mscb_ctl_t          ctl;
    mscb_stat_t         stat;
    logic [SLOT_W-1:0]  rd_addr;   // memory read address, issue or held stage
    logic [SLOT_W-1:0]  proc_idx;  // slot being updated this cycle
    logic [SLOT_W-1:0]  find_idx;  // slot under test for a set

    // sequencer: command decode, slot walk, result ordering
    mscb_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .proc_idx (proc_idx),
        .find_idx (find_idx)
    );

    // storage, arithmetic and the output register
    mscb_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .GEN_BITS    (GEN_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .stat              (stat),
        .rd_addr           (rd_addr),
        .proc_idx          (proc_idx),
        .find_idx          (find_idx),
        .delta             (delta),
        .rate              (rate),
        .delay             (delay),
        .is_loop           (is_loop),
        .slot              (slot),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .handle_slot       (handle_slot),
        .handle_generation (handle_generation),
        .handle_valid      (handle_valid),
        .table_full        (table_full),
        .last              (last)
    );

endmodule
